@@ hw/rtl/rtdtm_pkg.sv @@
// ----------------------------------------------------------------------------
// RTD trimmed mean thermometer package
// Shared types, register indexes and constants of the thermometer block.
// ----------------------------------------------------------------------------
package rtdtm_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_DEFAULT_R0 = 3'd0;
   localparam logic [2:0] REG_DEFAULT_A  = 3'd1;
   localparam logic [2:0] REG_CAL_R0     = 3'd2;
   localparam logic [2:0] REG_CAL_A      = 3'd3;
   localparam logic [2:0] REG_COEF_B     = 3'd4;

   // Group length and result limits.
   localparam logic [3:0]         LAST_SAMPLE   = 4'd9;
   localparam logic signed [17:0] TEMP_LOW      = -18'sd2560;
   localparam logic signed [17:0] TEMP_HIGH     = 18'sd23040;
   localparam logic [16:0]        QUOT_LIMIT    = 17'd40000;
   localparam logic [15:0]        TEMP_FALLBACK = 16'd6400;
   localparam logic [23:0]        OHM_SCALE     = 24'd16384000;
   localparam logic [39:0]        ROUND_HALF    = 40'd32767;
   localparam logic [16:0]        RECIP_FULL    = 17'd65535;

   // Configuration registers as seen by the solver.
   typedef struct packed {
      logic [26:0] default_r0;
      logic [30:0] default_a;
      logic [26:0] cal_r0;
      logic [30:0] cal_a;
      logic [31:0] coef_b;
   } cfg_type;

   // One finished group average from the front end.
   typedef struct packed {
      logic        valid;
      logic [15:0] data;
   } push_type;

   // Solver sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RES,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_M,
      ST_MUL_T,
      ST_DISC,
      ST_SQRT,
      ST_NUM,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

@@ hw/rtl/rtdtm_if.sv @@
// ----------------------------------------------------------------------------
// RTD thermometer channel interfaces
// Valid/ready channels for the sample stream and the result stream.
// ----------------------------------------------------------------------------
interface rtdtm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface rtdtm_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] raw_average;
   logic signed [15:0] temperature;
   logic               over_range;

   modport source (output valid, output raw_average, output temperature,
                   output over_range, input ready);
   modport sink   (input valid, input raw_average, input temperature,
                   input over_range, output ready);
endinterface

@@ hw/rtl/rtd_trimmed_mean_temperature.sv @@
// ----------------------------------------------------------------------------
// RTD trimmed mean thermometer
// Averages groups of ten samples with the extremes removed and converts the
// average into a temperature in 1/256 degree C.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req_chan  in         valid/ready          sample
//   rsp_chan  out        valid/ready          raw_average, temperature, over_range
//   csr_*     in         csr_wr_en            csr_index, csr_wr_data
//
// A sample is taken while the two-entry average queue has room.
// Every tenth sample starts the solver, which runs from the queue pop to the
// result through four multiplications, 64 square root steps, 88 divider steps
// and the single steps RES, DISC, NUM and FIN. A zero denominator or a
// negative discriminant skips ahead to the result.
// Reset is synchronous and clears the group, the queue and the sequencer.
// A stalled result holds the solver; samples keep flowing until the queue fills.
module rtd_trimmed_mean_temperature (
   input  logic        clock,
   input  logic        reset,
   rtdtm_req_if.sink   req_chan,
   rtdtm_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   import rtdtm_pkg::*;

   cfg_type     cfg_ff;
   push_type    push;
   logic        full;
   logic        not_empty;
   logic [15:0] head;
   logic        pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_r0 <= 27'd6553600;
         cfg_ff.default_a  <= 31'd16786021;
         cfg_ff.cal_r0     <= '0;
         cfg_ff.cal_a      <= '0;
         cfg_ff.coef_b     <= 32'hF64F_A809;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DEFAULT_R0: cfg_ff.default_r0 <= csr_wr_data[26:0];
            REG_DEFAULT_A:  cfg_ff.default_a  <= csr_wr_data[30:0];
            REG_CAL_R0:     cfg_ff.cal_r0     <= csr_wr_data[26:0];
            REG_CAL_A:      cfg_ff.cal_a      <= csr_wr_data[30:0];
            REG_COEF_B:     cfg_ff.coef_b     <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   rtdtm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .full     (full),
      .req_chan (req_chan),
      .push     (push)
   );

   rtdtm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   rtdtm_solve u_solve (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (not_empty),
      .q_data   (head),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

   // An overrange result carries the fallback temperature.
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.over_range |-> rsp_chan.temperature == 16'sd6400)
      else $error("overrange result without fallback temperature");

   // A valid temperature lies in the supported span.
   a_span: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.over_range |->
         (rsp_chan.temperature >= -16'sd2560) && (rsp_chan.temperature <= 16'sd23040))
      else $error("in-range result outside the supported span");

   // No result is offered right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result offered after reset");

endmodule

@@ hw/rtl/rtdtm_front.sv @@
// ----------------------------------------------------------------------------
// RTD thermometer front end
// Accepts samples, tracks sum, maximum and minimum, and emits trimmed means.
// ----------------------------------------------------------------------------
module rtdtm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               full,
   rtdtm_req_if.sink          req_chan,
   output rtdtm_pkg::push_type push
);
   import rtdtm_pkg::*;

   logic [3:0]  count_ff, count_in;
   logic [19:0] sum_ff, sum_in;
   logic [15:0] max_ff, max_in;
   logic [15:0] min_ff, min_in;
   logic        accept;
   logic        last;
   logic [19:0] trimmed;

   assign req_chan.ready = !full;
   assign accept = req_chan.valid && !full;
   assign last   = (count_ff == LAST_SAMPLE);

   // Fold the new item into the group statistics.
   always_comb begin
      sum_in = sum_ff + {4'b0, req_chan.sample};
      max_in = (req_chan.sample > max_ff) ? req_chan.sample : max_ff;
      min_in = (req_chan.sample < min_ff) ? req_chan.sample : min_ff;
      count_in = count_ff + 4'd1;
      trimmed = sum_in - {4'b0, max_in} - {4'b0, min_in};
   end

   assign push.valid = accept && last;
   assign push.data  = trimmed[18:3];

   // Group registers; the tenth item restarts the group.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         max_ff   <= '0;
         min_ff   <= '1;
      end else if (accept) begin
         if (last) begin
            count_ff <= '0;
            sum_ff   <= '0;
            max_ff   <= '0;
            min_ff   <= '1;
         end else begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            max_ff   <= max_in;
            min_ff   <= min_in;
         end
      end
   end

endmodule

@@ hw/rtl/rtdtm_queue.sv @@
// ----------------------------------------------------------------------------
// RTD thermometer average queue
// Two-entry queue of trimmed means between the front end and the solver.
// ----------------------------------------------------------------------------
module rtdtm_queue (
   input  logic               clock,
   input  logic               reset,
   input  rtdtm_pkg::push_type push,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output logic [15:0]        head
);
   import rtdtm_pkg::*;

   logic [15:0] mem_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  fill_ff;
   logic        do_push, do_pop;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = mem_ff[rptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push.data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wptr_ff <= !wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= !rptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

@@ hw/rtl/rtdtm_solve.sv @@
// ----------------------------------------------------------------------------
// RTD thermometer solver
// Sequencer that turns one trimmed mean into a temperature by solving the
// Callendar-Van Dusen quadratic with a shared multiplier, a bit-pair square
// root and a restoring divider.
// ----------------------------------------------------------------------------
module rtdtm_solve (
   input  logic              clock,
   input  logic              reset,
   input  rtdtm_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  logic [15:0]       q_data,
   output logic              q_pop,
   rtdtm_rsp_if.source       rsp_chan
);
   import rtdtm_pkg::*;

   state_type state_ff, state_in;

   logic [15:0]  avg_ff;
   logic [23:0]  r_ff;
   logic [63:0]  p_ff, m_ff;
   logic [127:0] d_ff, acc_ff;
   logic [63:0]  mx_ff, my_ff, prod_ff;
   logic [2:0]   mcnt_ff;
   logic [65:0]  srem_ff;
   logic [63:0]  root_ff;
   logic [58:0]  drem_ff;
   logic [16:0]  quot_ff;
   logic         big_ff, fail_ff, tneg_ff;
   logic [6:0]   cnt_ff;

   logic               rsp_valid_ff;
   logic [15:0]        rsp_raw_ff;
   logic signed [15:0] rsp_temp_ff;
   logic               rsp_over_ff;

   // Coefficient selection.
   logic        use_cal;
   logic [26:0] r0_w;
   logic [30:0] a_w;
   logic        bneg_w;
   logic [31:0] bmag_w;
   logic        no_den;

   always_comb begin
      use_cal = (cfg.cal_r0 != '0) && (cfg.cal_a != '0);
      r0_w    = use_cal ? cfg.cal_r0 : cfg.default_r0;
      a_w     = use_cal ? cfg.cal_a : cfg.default_a;
      bneg_w  = cfg.coef_b[31];
      bmag_w  = bneg_w ? (~cfg.coef_b + 32'd1) : cfg.coef_b;
      no_den  = (r0_w == '0) || (bmag_w == '0);
   end

   // Resistance: round(avg * 16384000 / 65535) by folding 2^16 = 65535 + 1.
   logic [39:0] rn;
   logic [24:0] fold1;
   logic [16:0] fold2;
   logic [23:0] rcalc;

   always_comb begin
      rn    = ({24'b0, avg_ff} * {16'b0, OHM_SCALE}) + ROUND_HALF;
      fold1 = {1'b0, rn[39:16]} + {9'b0, rn[15:0]};
      fold2 = {8'b0, fold1[24:16]} + {1'b0, fold1[15:0]};
      rcalc = rn[39:16] + {15'b0, fold1[24:16]} + {23'b0, (fold2 >= RECIP_FULL)};
   end

   // Distance from R0.
   logic        dr_neg;
   logic [26:0] dr_w;

   always_comb begin
      dr_neg = {3'b0, r_ff} > r0_w;
      dr_w   = dr_neg ? ({3'b0, r_ff} - r0_w) : (r0_w - {3'b0, r_ff});
   end

   // Shared 32x32 multiplier, one partial product a cycle.
   logic [1:0]   mk, pk;
   logic [31:0]  pa, pb;
   logic [63:0]  prod_in;
   logic [127:0] shifted;
   logic [127:0] mul_sum;
   logic         mul_done;

   always_comb begin
      mk       = mcnt_ff[1:0];
      pk       = mk - 2'd1;
      pa       = mk[0] ? mx_ff[63:32] : mx_ff[31:0];
      pb       = mk[1] ? my_ff[63:32] : my_ff[31:0];
      prod_in  = pa * pb;
      case (pk)
         2'd0:    shifted = {64'b0, prod_ff};
         2'd3:    shifted = {prod_ff, 64'b0};
         default: shifted = {32'b0, prod_ff, 32'b0};
      endcase
      mul_sum  = acc_ff + shifted;
      mul_done = (mcnt_ff == 3'd4);
   end

   // Discriminant update.
   logic [127:0] t2;
   logic         disc_sub, disc_fail;

   always_comb begin
      t2        = acc_ff << 18;
      disc_sub  = (bneg_w == dr_neg);
      disc_fail = disc_sub && (d_ff < t2);
   end

   // Square root step: two radicand bits a cycle.
   logic [67:0] s_try, s_trial, s_diff;
   logic        s_ge;

   always_comb begin
      s_try   = {srem_ff, d_ff[127:126]};
      s_trial = {2'b0, root_ff, 2'b01};
      s_diff  = s_try - s_trial;
      s_ge    = (s_try >= s_trial);
   end

   // Numerator of the temperature division.
   logic        n_neg;
   logic [63:0] nmag;
   logic [87:0] num;

   always_comb begin
      n_neg = root_ff < p_ff;
      nmag  = n_neg ? (p_ff - root_ff) : (root_ff - p_ff);
      num   = {1'b0, nmag, 23'b0} + {25'b0, m_ff[63:1]};
   end

   // Division step: one quotient bit a cycle.
   logic [59:0] q_try, q_diff;
   logic        q_ge;

   always_comb begin
      q_try  = {drem_ff, d_ff[87]};
      q_ge   = (q_try >= {1'b0, m_ff[58:0]});
      q_diff = q_try - {1'b0, m_ff[58:0]};
   end

   // Final temperature and range check.
   logic signed [17:0] t_w;
   logic               over_w;

   always_comb begin
      t_w    = tneg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
      over_w = fail_ff || big_ff || (quot_ff > QUOT_LIMIT) ||
               (t_w < TEMP_LOW) || (t_w > TEMP_HIGH);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_RES;
         ST_RES:   state_in = no_den ? ST_FIN : ST_MUL_P;
         ST_MUL_P: if (mul_done) state_in = ST_MUL_D;
         ST_MUL_D: if (mul_done) state_in = ST_MUL_M;
         ST_MUL_M: if (mul_done) state_in = ST_MUL_T;
         ST_MUL_T: if (mul_done) state_in = ST_DISC;
         ST_DISC:  state_in = disc_fail ? ST_FIN : ST_SQRT;
         ST_SQRT:  if (cnt_ff == 7'd63) state_in = ST_NUM;
         ST_NUM:   state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 7'd87) state_in = ST_FIN;
         ST_FIN:   if (!rsp_valid_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      q_pop = (state_ff == ST_IDLE) && q_valid;
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            avg_ff <= q_data;
         end
         ST_RES: begin
            r_ff    <= rcalc;
            fail_ff <= no_den;
            mx_ff   <= {37'b0, r0_w};
            my_ff   <= {33'b0, a_w};
            mcnt_ff <= '0;
            acc_ff  <= '0;
         end
         ST_MUL_P, ST_MUL_D, ST_MUL_M, ST_MUL_T: begin
            if (!mul_done) begin
               prod_ff <= prod_in;
               mcnt_ff <= mcnt_ff + 3'd1;
               if (mcnt_ff != 3'd0) begin
                  acc_ff <= mul_sum;
               end
            end else begin
               mcnt_ff <= '0;
               case (state_ff)
                  ST_MUL_P: begin
                     acc_ff <= '0;
                     p_ff   <= mul_sum[63:0];
                     mx_ff  <= mul_sum[63:0];
                     my_ff  <= mul_sum[63:0];
                  end
                  ST_MUL_D: begin
                     acc_ff <= '0;
                     d_ff   <= mul_sum;
                     mx_ff  <= {37'b0, r0_w};
                     my_ff  <= {32'b0, bmag_w};
                  end
                  ST_MUL_M: begin
                     acc_ff <= '0;
                     m_ff   <= mul_sum[63:0];
                     mx_ff  <= mul_sum[63:0];
                     my_ff  <= {37'b0, dr_w};
                  end
                  default: begin
                     acc_ff <= mul_sum;
                  end
               endcase
            end
         end
         ST_DISC: begin
            fail_ff <= disc_fail;
            d_ff    <= disc_sub ? (d_ff - t2) : (d_ff + t2);
            srem_ff <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         ST_SQRT: begin
            srem_ff <= s_ge ? s_diff[65:0] : s_try[65:0];
            root_ff <= {root_ff[62:0], s_ge};
            d_ff    <= d_ff << 2;
            cnt_ff  <= cnt_ff + 7'd1;
         end
         ST_NUM: begin
            d_ff    <= {40'b0, num};
            tneg_ff <= n_neg ^ bneg_w;
            drem_ff <= '0;
            quot_ff <= '0;
            big_ff  <= 1'b0;
            cnt_ff  <= '0;
         end
         ST_DIV: begin
            drem_ff <= q_ge ? q_diff[58:0] : q_try[58:0];
            quot_ff <= {quot_ff[15:0], q_ge};
            big_ff  <= big_ff | quot_ff[16];
            d_ff    <= d_ff << 1;
            cnt_ff  <= cnt_ff + 7'd1;
         end
         default: begin
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_FIN) && !rsp_valid_ff) begin
         rsp_raw_ff  <= avg_ff;
         rsp_over_ff <= over_w;
         rsp_temp_ff <= over_w ? $signed(TEMP_FALLBACK) : t_w[15:0];
      end
   end

   // Sequencer state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_FIN) && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.raw_average = rsp_raw_ff;
   assign rsp_chan.temperature = rsp_temp_ff;
   assign rsp_chan.over_range  = rsp_over_ff;

endmodule
